@@ sv/ipv4c_pkg.sv @@
// ----------------------------------------------------------------------------
// ipv4c_pkg
// Shared types and constants of the IPv4 header checksum checker.
// ----------------------------------------------------------------------------
package ipv4c_pkg;

	// check status codes
	typedef enum logic [1:0] {
		STATUS_NOT_CHECKED = 2'd0,
		STATUS_GOOD        = 2'd1,
		STATUS_BAD         = 2'd2
	} status_t;

	// word positions within the header
	localparam logic [4:0] IDX_VER_IHL  = 5'd0;
	localparam logic [4:0] IDX_TOT_LEN  = 5'd1;
	localparam logic [4:0] IDX_IDENT    = 5'd2;
	localparam logic [4:0] IDX_FLAGS    = 5'd3;
	localparam logic [4:0] IDX_TTL_PROT = 5'd4;
	localparam logic [4:0] IDX_CHECKSUM = 5'd5;

	// a result never comes before the last word of the fixed header part
	localparam logic [4:0] MIN_SPAN     = 5'd10;

	// one result item
	typedef struct packed {
		logic [3:0]  version;
		logic [3:0]  header_len;
		logic [15:0] datagram_len;
		logic [15:0] ident;
		logic        reserved_bit;
		logic        dont_fragment;
		logic        more_fragments;
		logic [12:0] frag_offset;
		logic [7:0]  time_to_live;
		logic [7:0]  protocol;
		logic [15:0] calc_checksum;
		status_t     check_status;
	} result_t;

	// parser status seen by the output stage
	typedef struct packed {
		logic in_header;
		logic will_emit;
	} core_stat_t;

endpackage

@@ sv/ipv4c_if.sv @@
// ----------------------------------------------------------------------------
// ipv4c interfaces
// Valid/ready channels for header words, results and the config register.
// ----------------------------------------------------------------------------
interface ipv4c_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] header_word;
	logic        first_word;

	modport source (output valid, output header_word, output first_word, input ready);
	modport sink (input valid, input header_word, input first_word, output ready);
endinterface

interface ipv4c_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  version;
	logic [3:0]  header_len;
	logic [15:0] datagram_len;
	logic [15:0] ident;
	logic        reserved_bit;
	logic        dont_fragment;
	logic        more_fragments;
	logic [12:0] frag_offset;
	logic [7:0]  time_to_live;
	logic [7:0]  protocol;
	logic [15:0] calc_checksum;
	logic [1:0]  check_status;

	modport source (output valid, output version, output header_len, output datagram_len,
		output ident, output reserved_bit, output dont_fragment, output more_fragments,
		output frag_offset, output time_to_live, output protocol, output calc_checksum,
		output check_status, input ready);
	modport sink (input valid, input version, input header_len, input datagram_len,
		input ident, input reserved_bit, input dont_fragment, input more_fragments,
		input frag_offset, input time_to_live, input protocol, input calc_checksum,
		input check_status, output ready);
endinterface

interface ipv4c_cfg_if;
	logic valid;
	logic ready;
	logic check_enable;

	modport source (output valid, output check_enable, input ready);
	modport sink (input valid, input check_enable, output ready);
endinterface

@@ sv/ipv4c_core.sv @@
// ----------------------------------------------------------------------------
// ipv4c_core
// Header parser: tracks word index, captures fields and folds the
// one's-complement sum; flags the word that closes a header.
// ----------------------------------------------------------------------------
module ipv4c_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [15:0]          header_word,
	input  logic                 first_word,
	input  logic                 check_enable,
	output logic                 emit,
	output ipv4c_pkg::result_t   result,
	output ipv4c_pkg::core_stat_t stat
);

	logic [4:0]  idx_q;
	logic [15:0] sum_q;
	logic        in_hdr_q;
	logic [3:0]  ver_q;
	logic [3:0]  ihl_q;
	logic [15:0] tlen_q;
	logic [15:0] ident_q;
	logic [15:0] flags_q;
	logic [7:0]  ttl_q;
	logic [7:0]  proto_q;
	logic [15:0] stored_q;

	logic        active;
	logic [4:0]  idx_eff;
	logic [15:0] sum_eff;
	logic [3:0]  ihl_eff;
	logic [3:0]  ver_eff;
	logic [4:0]  lim;
	logic [4:0]  last;
	logic [4:0]  lim_q;
	logic [4:0]  last_q;
	logic [16:0] sum_wide;
	logic [15:0] sum_next;
	logic [15:0] calc;
	logic [15:0] stored_eff;

	// resolve the effective state: a start flag opens a fresh header
	always_comb begin
		active  = first_word || in_hdr_q;
		idx_eff = first_word ? ipv4c_pkg::IDX_VER_IHL : idx_q;
		sum_eff = first_word ? 16'h0000 : sum_q;
		ihl_eff = (idx_eff == ipv4c_pkg::IDX_VER_IHL) ? header_word[11:8] : ihl_q;
		ver_eff = (idx_eff == ipv4c_pkg::IDX_VER_IHL) ? header_word[15:12] : ver_q;
		stored_eff = (idx_eff == ipv4c_pkg::IDX_CHECKSUM) ? header_word : stored_q;
	end

	// last word index: max(2*IHL, 10) - 1
	always_comb begin
		lim    = {ihl_eff, 1'b0};
		last   = ((lim > ipv4c_pkg::MIN_SPAN) ? lim : ipv4c_pkg::MIN_SPAN) - 5'd1;
		lim_q  = {ihl_q, 1'b0};
		last_q = ((lim_q > ipv4c_pkg::MIN_SPAN) ? lim_q : ipv4c_pkg::MIN_SPAN) - 5'd1;
	end

	// fold the word in with end-around carry, skipping the stored checksum and words past 2*IHL
	always_comb begin
		sum_wide = {1'b0, sum_eff} + {1'b0, header_word};
		if (idx_eff < lim && idx_eff != ipv4c_pkg::IDX_CHECKSUM) begin
			sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
		end else begin
			sum_next = sum_eff;
		end
		calc = ~sum_next;
	end

	assign emit = active && (idx_eff >= last);

	// assemble the result from captured fields and the current word
	always_comb begin
		result.version        = ver_eff;
		result.header_len     = ihl_eff;
		result.datagram_len   = tlen_q;
		result.ident          = ident_q;
		result.reserved_bit   = flags_q[15];
		result.dont_fragment  = flags_q[14];
		result.more_fragments = flags_q[13];
		result.frag_offset    = flags_q[12:0];
		result.time_to_live   = ttl_q;
		result.protocol       = proto_q;
		result.calc_checksum  = calc;
		if (!check_enable) begin
			result.check_status = ipv4c_pkg::STATUS_NOT_CHECKED;
		end else if (calc == stored_eff) begin
			result.check_status = ipv4c_pkg::STATUS_GOOD;
		end else begin
			result.check_status = ipv4c_pkg::STATUS_BAD;
		end
	end

	// a non-start word can close the header only when the index is at its end
	assign stat.in_header = in_hdr_q;
	assign stat.will_emit = in_hdr_q && (idx_q >= last_q);

	// advance index, sum and header state on each accepted beat within a header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= 5'd0;
			sum_q    <= 16'h0000;
			in_hdr_q <= 1'b0;
			ihl_q    <= 4'd0;
		end else if (take && active) begin
			ihl_q <= ihl_eff;
			if (emit) begin
				idx_q    <= 5'd0;
				sum_q    <= sum_next;
				in_hdr_q <= 1'b0;
			end else begin
				idx_q    <= idx_eff + 5'd1;
				sum_q    <= sum_next;
				in_hdr_q <= 1'b1;
			end
		end
	end

	// capture header fields by word position
	always_ff @(posedge clk) begin
		if (take && active) begin
			case (idx_eff)
				ipv4c_pkg::IDX_VER_IHL:  ver_q    <= header_word[15:12];
				ipv4c_pkg::IDX_TOT_LEN:  tlen_q   <= header_word;
				ipv4c_pkg::IDX_IDENT:    ident_q  <= header_word;
				ipv4c_pkg::IDX_FLAGS:    flags_q  <= header_word;
				ipv4c_pkg::IDX_TTL_PROT: begin
					ttl_q   <= header_word[15:8];
					proto_q <= header_word[7:0];
				end
				ipv4c_pkg::IDX_CHECKSUM: stored_q <= header_word;
				default: ;
			endcase
		end
	end

endmodule

@@ sv/ipv4_header_checksum_checker_top.sv @@
// ----------------------------------------------------------------------------
// ipv4_header_checksum_checker_top
// Checks the IPv4 header checksum and reports the parsed header fields.
// ----------------------------------------------------------------------------
// Usage:
//   hdr_in  - header words, big-endian 16-bit beats; first_word marks word 0.
//             A start flag in the middle of a header restarts it, and words
//             outside a header are dropped.
//   res_out - one result beat per header, after word max(2*IHL,10)-1:
//             captured fields, the complemented one's-complement sum and a
//             status (not checked, good, bad).
//   cfg     - writes check_enable; always ready. Write only while idle.
// Throughput: one word per cycle unless a closing word waits; set by the single
// 16-bit end-around add between the parser state and the result register.
// Latency: the result is valid in the cycle after its closing word.
// Stall: the result register holds while res_out.ready is low; words keep
// flowing until the header reaches its closing index, and the word at that
// index waits until the result register is free.
// Reset: arst_n clears header state, the result valid and check_enable.
// ----------------------------------------------------------------------------
module ipv4_header_checksum_checker_top (
	input  logic         clk,
	input  logic         arst_n,
	ipv4c_word_if.sink   hdr_in,
	ipv4c_res_if.source  res_out,
	ipv4c_cfg_if.sink    cfg
);

	logic                  check_en_q;
	logic                  take;
	logic                  emit;
	logic                  res_valid_q;
	ipv4c_pkg::result_t    result;
	ipv4c_pkg::result_t    res_q;
	ipv4c_pkg::core_stat_t stat;

	// config register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_en_q <= 1'b0;
		end else if (cfg.valid) begin
			check_en_q <= cfg.check_enable;
		end
	end

	// accept unless a closing beat would meet a full, stalled result register
	assign hdr_in.ready = !stat.will_emit || !res_valid_q || res_out.ready;
	assign take         = hdr_in.valid && hdr_in.ready;

	ipv4c_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.header_word  (hdr_in.header_word),
		.first_word   (hdr_in.first_word),
		.check_enable (check_en_q),
		.emit         (emit),
		.result       (result),
		.stat         (stat)
	);

	// result register: load on a closing beat, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= result;
		end
	end

	assign res_out.valid          = res_valid_q;
	assign res_out.version        = res_q.version;
	assign res_out.header_len     = res_q.header_len;
	assign res_out.datagram_len   = res_q.datagram_len;
	assign res_out.ident          = res_q.ident;
	assign res_out.reserved_bit   = res_q.reserved_bit;
	assign res_out.dont_fragment  = res_q.dont_fragment;
	assign res_out.more_fragments = res_q.more_fragments;
	assign res_out.frag_offset    = res_q.frag_offset;
	assign res_out.time_to_live   = res_q.time_to_live;
	assign res_out.protocol       = res_q.protocol;
	assign res_out.calc_checksum  = res_q.calc_checksum;
	assign res_out.check_status   = res_q.check_status;

	// a closing beat is one the ready logic anticipated
	a_emit_expected: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit |-> stat.will_emit)
		else $error("closing beat not anticipated by ready logic");

	// never overwrite a pending result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit |-> (!res_valid_q || res_out.ready))
		else $error("result register overwritten");

	// a closed header leaves the parser outside any header
	a_header_closed: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit |=> !stat.in_header)
		else $error("header still open after result");

	// status code is always one of the three defined values
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.check_status == ipv4c_pkg::STATUS_NOT_CHECKED
			|| res_q.check_status == ipv4c_pkg::STATUS_GOOD
			|| res_q.check_status == ipv4c_pkg::STATUS_BAD))
		else $error("undefined check status");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams IPv4 headers into the checksum checker and compares every result
// beat, field by field, against a cycle-free header parser kept in step with
// each accepted word. Covers stray words, restarted and short headers, both
// check_enable settings, random idling on both sides and a long result stall.
// ----------------------------------------------------------------------------
module testbench;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;
	typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

	localparam int FULL_HEADER   = 32;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n;

	ipv4c_word_if hdr_if();
	ipv4c_res_if  res_if();
	ipv4c_cfg_if  cfg_if();

	ipv4_header_checksum_checker_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr_in (hdr_if),
		.res_out(res_if),
		.cfg    (cfg_if)
	);

	// parser shadow: header being collected and the enable register
	logic [4:0]  shadow_idx    = '0;
	logic [15:0] shadow_sum    = '0;
	logic [3:0]  shadow_ver    = '0;
	logic [3:0]  shadow_ihl    = '0;
	logic [15:0] shadow_totlen = '0;
	logic [15:0] shadow_ident  = '0;
	logic [15:0] shadow_flags  = '0;
	logic [7:0]  shadow_ttl    = '0;
	logic [7:0]  shadow_proto  = '0;
	logic [15:0] shadow_stored = '0;
	logic        shadow_open   = 1'b0;
	logic        shadow_chk_en = 1'b0;

	ipv4c_pkg::result_t header_reports[$];
	int       mismatches       = 0;
	int       words_in_headers = 0;
	int       tx_gap_max       = 0;
	int       tx_burst_left    = 0;
	rx_mode_t rx_mode          = RX_ALWAYS;
	logic     rx_hold_req      = 1'b0;

	always #5 clk = ~clk;

	function automatic logic [15:0] ones_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// advance the shadow parser by one accepted word; queue a report on the closing word
	task automatic parse_header_word(input logic [15:0] w, input logic first);
		int                 covered;
		int                 last_idx;
		ipv4c_pkg::result_t r;
		if (first) begin
			shadow_open   = 1'b1;
			shadow_idx    = '0;
			shadow_sum    = '0;
			shadow_ver    = '0;
			shadow_ihl    = '0;
			shadow_totlen = '0;
			shadow_ident  = '0;
			shadow_flags  = '0;
			shadow_ttl    = '0;
			shadow_proto  = '0;
			shadow_stored = '0;
		end else if (!shadow_open) begin
			return;
		end
		case (shadow_idx)
			ipv4c_pkg::IDX_VER_IHL: begin
				shadow_ver = w[15:12];
				shadow_ihl = w[11:8];
			end
			ipv4c_pkg::IDX_TOT_LEN:  shadow_totlen = w;
			ipv4c_pkg::IDX_IDENT:    shadow_ident = w;
			ipv4c_pkg::IDX_FLAGS:    shadow_flags = w;
			ipv4c_pkg::IDX_TTL_PROT: begin
				shadow_ttl   = w[15:8];
				shadow_proto = w[7:0];
			end
			ipv4c_pkg::IDX_CHECKSUM: shadow_stored = w;
			default: ;
		endcase
		covered = 2 * int'(shadow_ihl);
		if (int'(shadow_idx) < covered && shadow_idx != ipv4c_pkg::IDX_CHECKSUM)
			shadow_sum = ones_add16(shadow_sum, w);
		last_idx = ((covered > int'(ipv4c_pkg::MIN_SPAN)) ? covered
			: int'(ipv4c_pkg::MIN_SPAN)) - 1;
		if (int'(shadow_idx) < last_idx) begin
			shadow_idx = shadow_idx + 5'd1;
			return;
		end
		r.version        = shadow_ver;
		r.header_len     = shadow_ihl;
		r.datagram_len   = shadow_totlen;
		r.ident          = shadow_ident;
		r.reserved_bit   = shadow_flags[15];
		r.dont_fragment  = shadow_flags[14];
		r.more_fragments = shadow_flags[13];
		r.frag_offset    = shadow_flags[12:0];
		r.time_to_live   = shadow_ttl;
		r.protocol       = shadow_proto;
		r.calc_checksum  = ~shadow_sum;
		if (!shadow_chk_en)
			r.check_status = ipv4c_pkg::STATUS_NOT_CHECKED;
		else if (r.calc_checksum == shadow_stored)
			r.check_status = ipv4c_pkg::STATUS_GOOD;
		else
			r.check_status = ipv4c_pkg::STATUS_BAD;
		header_reports.push_back(r);
		shadow_open = 1'b0;
		shadow_idx  = '0;
	endtask

	// offer one word; open a random gap when the current burst is used up
	task automatic send_word(input logic [15:0] w, input logic first);
		int gap;
		@(negedge clk);
		if (tx_gap_max > 0 && tx_burst_left == 0) begin
			gap = $urandom_range(1, tx_gap_max);
			hdr_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
			tx_burst_left = $urandom_range(1, 12);
		end
		hdr_if.valid       = 1'b1;
		hdr_if.header_word = w;
		hdr_if.first_word  = first;
		do @(posedge clk); while (!hdr_if.ready);
		parse_header_word(w, first);
		if (tx_burst_left > 0)
			tx_burst_left--;
	endtask

	// build a header of the given length and send its first cut words
	task automatic send_header(input logic [3:0] hl, input bit good_sum, input fill_t fill,
			input int cut);
		logic [15:0] words [30];
		logic [15:0] sum;
		int          covered;
		int          span;
		covered = 2 * int'(hl);
		span    = (covered > int'(ipv4c_pkg::MIN_SPAN)) ? covered : int'(ipv4c_pkg::MIN_SPAN);
		for (int i = 0; i < span; i++) begin
			case (fill)
				FILL_ONES:  words[i] = 16'hffff;
				FILL_ZEROS: words[i] = 16'h0000;
				default:    words[i] = 16'($urandom);
			endcase
		end
		words[0][11:8] = hl;
		if (fill == FILL_RANDOM && $urandom_range(0, 3) != 0)
			words[0][15:12] = 4'd4;
		sum = '0;
		for (int i = 0; i < covered; i++)
			if (i != int'(ipv4c_pkg::IDX_CHECKSUM))
				sum = ones_add16(sum, words[i]);
		if (good_sum)
			words[ipv4c_pkg::IDX_CHECKSUM] = ~sum;
		for (int i = 0; i < span && i < cut; i++)
			send_word(words[i], i == 0);
		words_in_headers += (cut < span) ? cut : span;
	endtask

	// drop valid and wait until every queued report has come back
	task automatic drain_results();
		int waited;
		@(negedge clk);
		hdr_if.valid = 1'b0;
		waited = 0;
		while (header_reports.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (header_reports.size() != 0) begin
			$display("%0t: %0d header results never arrived", $time, header_reports.size());
			mismatches++;
			header_reports.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_check_enable(input logic en);
		drain_results();
		@(negedge clk);
		cfg_if.valid        = 1'b1;
		cfg_if.check_enable = en;
		do @(posedge clk); while (!cfg_if.ready);
		shadow_chk_en = en;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic shuffle_idling();
		case ($urandom_range(0, 3))
			0:       tx_gap_max = 0;
			1:       tx_gap_max = 2;
			2:       tx_gap_max = 5;
			default: tx_gap_max = 9;
		endcase
		rx_mode = rx_mode_t'($urandom_range(0, 2));
	endtask

	// mostly whole headers, some cut short, some stray words between them
	task automatic run_random_headers(input int budget);
		int         start;
		int         pick;
		int         span;
		logic [3:0] hl;
		start = words_in_headers;
		while (words_in_headers - start < budget) begin
			if ($urandom_range(0, 7) == 0)
				shuffle_idling();
			pick = $urandom_range(0, 19);
			hl   = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
			span = (2 * int'(hl) > int'(ipv4c_pkg::MIN_SPAN)) ? 2 * int'(hl)
				: int'(ipv4c_pkg::MIN_SPAN);
			if (pick == 0) begin
				repeat ($urandom_range(1, 3)) send_word(16'($urandom), 1'b0);
			end else if (pick == 1) begin
				send_header(hl, 1'b1, FILL_RANDOM, $urandom_range(1, span - 1));
			end else begin
				send_header(hl, $urandom_range(0, 2) != 0, FILL_RANDOM, FULL_HEADER);
			end
		end
	endtask

	task automatic test_directed();
		tx_gap_max = 0;
		rx_mode    = RX_ALWAYS;
		// stray words with no header open
		send_word(16'hffff, 1'b0);
		send_word(16'h0000, 1'b0);
		// partial header, restarted by a zero-length header under reset config
		send_header(4'd15, 1'b0, FILL_RANDOM, 2);
		send_header(4'd0, 1'b1, FILL_ZEROS, FULL_HEADER);
		write_check_enable(1'b1);
		send_header(4'd5, 1'b1, FILL_ONES, FULL_HEADER);
	endtask

	task automatic test_unchecked_stream();
		write_check_enable(1'b0);
		shuffle_idling();
		run_random_headers(400);
	endtask

	task automatic test_checked_stream();
		write_check_enable(1'b1);
		shuffle_idling();
		run_random_headers(950);
	endtask

	// hold the result side off while words keep coming, then pause until drained
	task automatic test_result_backpressure();
		tx_gap_max  = 0;
		rx_mode     = RX_ALWAYS;
		rx_hold_req = 1'b1;
		send_header(4'd5, 1'b1, FILL_RANDOM, FULL_HEADER);
		send_header(4'd15, 1'b1, FILL_RANDOM, FULL_HEADER);
		send_header(4'd5, 1'b0, FILL_RANDOM, FULL_HEADER);
		send_header(4'd0, 1'b1, FILL_RANDOM, FULL_HEADER);
		send_header(4'd5, 1'b1, FILL_RANDOM, FULL_HEADER);
		drain_results();
		shuffle_idling();
		run_random_headers(60);
	endtask

	task automatic test_enable_toggle();
		write_check_enable(1'b0);
		run_random_headers(200);
		write_check_enable(1'b1);
		run_random_headers(200);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// result side: long hold-off on request, otherwise the current stall pattern
	initial begin
		int          hold_left;
		int unsigned tick;
		res_if.ready = 1'b0;
		hold_left    = 0;
		tick         = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (rx_hold_req) begin
				hold_left   = HOLD_CYCLES;
				rx_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				res_if.ready = 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_RANDOM:  res_if.ready = 1'($urandom_range(0, 1));
					RX_PATTERN: res_if.ready = (tick % 7) >= 2;
					default:    res_if.ready = 1'b1;
				endcase
			end
		end
	end

	// compare each result beat with the oldest queued report
	always @(posedge clk) begin
		ipv4c_pkg::result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (header_reports.size() == 0) begin
				$display("%0t: result beat with none expected, checksum %0h", $time,
					res_if.calc_checksum);
				mismatches++;
			end else begin
				want = header_reports.pop_front();
				check_field("version", 32'(want.version), 32'(res_if.version));
				check_field("header_len", 32'(want.header_len), 32'(res_if.header_len));
				check_field("datagram_len", 32'(want.datagram_len),
					32'(res_if.datagram_len));
				check_field("ident", 32'(want.ident), 32'(res_if.ident));
				check_field("reserved_bit", 32'(want.reserved_bit),
					32'(res_if.reserved_bit));
				check_field("dont_fragment", 32'(want.dont_fragment),
					32'(res_if.dont_fragment));
				check_field("more_fragments", 32'(want.more_fragments),
					32'(res_if.more_fragments));
				check_field("frag_offset", 32'(want.frag_offset), 32'(res_if.frag_offset));
				check_field("time_to_live", 32'(want.time_to_live),
					32'(res_if.time_to_live));
				check_field("protocol", 32'(want.protocol), 32'(res_if.protocol));
				check_field("calc_checksum", 32'(want.calc_checksum),
					32'(res_if.calc_checksum));
				check_field("check_status", 32'(want.check_status),
					32'(res_if.check_status));
			end
		end
	end

	initial begin
		#3_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		hdr_if.valid        = 1'b0;
		hdr_if.header_word  = '0;
		hdr_if.first_word   = 1'b0;
		cfg_if.valid        = 1'b0;
		cfg_if.check_enable = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_unchecked_stream();
		test_checked_stream();
		test_result_backpressure();
		test_enable_toggle();
		drain_results();

		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
sv/ipv4c_pkg.sv
sv/ipv4c_if.sv
sv/ipv4c_core.sv
sv/ipv4_header_checksum_checker_top.sv
dv/testbench.sv
